/* rtl/core/kpef_pkg.sv */
package kpef_pkg;

    // Field widths of one beat
    localparam int unsigned NUM_KEYS = 3;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned CODE_W   = 8;

    // Level of every key when nothing is pressed
    localparam logic [LEVEL_W-1:0] LEVELS_RELEASED = 3'b111;

    // Configuration register indexes (byte address 4*i)
    localparam int unsigned REG_ADDR_W = 4;
    localparam logic [1:0]  REG_FIRST_KEY_CODE  = 2'd0;
    localparam logic [1:0]  REG_SECOND_KEY_CODE = 2'd1;
    localparam logic [1:0]  REG_THIRD_KEY_CODE  = 2'd2;

    // Reset values of the key codes
    localparam logic [CODE_W-1:0] FIRST_KEY_CODE_RST  = 8'd1;
    localparam logic [CODE_W-1:0] SECOND_KEY_CODE_RST = 8'd2;
    localparam logic [CODE_W-1:0] THIRD_KEY_CODE_RST  = 8'd3;

    typedef logic [CODE_W-1:0] code_t;
    typedef code_t [NUM_KEYS-1:0] code_set_t;

    typedef enum logic [0:0]
    {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t            opcode;
        logic [LEVEL_W-1:0] key_levels;
    } item_t;

    typedef struct packed
    {
        code_t key_code;
        logic  queue_was_empty;
    } result_t;

endpackage

/* rtl/core/kpef_in_reg.sv */
module kpef_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kpef_pkg::item_t in_item,
    output logic            item_valid,
    output kpef_pkg::item_t item,
    input  logic            item_take
);

    logic            valid_reg;
    logic            valid_next;
    kpef_pkg::item_t item_reg;

    // Accept a new beat when the register is empty or drains this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new beat arrives
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/kpef_edge_queue.sv */
module kpef_edge_queue
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  kpef_pkg::code_set_t key_codes,
    input  logic                item_valid,
    input  kpef_pkg::item_t     item,
    output logic                item_take,
    input  logic                res_free,
    output logic                res_valid,
    output kpef_pkg::result_t   res
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW = PW + 2;
    localparam int unsigned OW = CW + 2;

    logic [kpef_pkg::LEVEL_W-1:0] prev_levels_reg;
    logic [kpef_pkg::LEVEL_W-1:0] prev_levels_next;
    logic [PW-1:0]                wr_slot_reg;
    logic [PW-1:0]                wr_slot_next;
    logic [PW-1:0]                rd_slot_reg;
    logic [PW-1:0]                rd_slot_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;

    kpef_pkg::code_t              store [QUEUE_DEPTH];

    logic                         is_tick;
    logic                         tick_fire;
    logic                         pop;
    logic [kpef_pkg::LEVEL_W-1:0] edges;
    logic [CW-1:0]                space;
    logic [kpef_pkg::NUM_KEYS-1:0] wr_en;
    logic [PW-1:0]                wr_addr [kpef_pkg::NUM_KEYS];
    logic [1:0]                   pushed;

    // Advance a slot index by a small step with wrap at the queue depth
    function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
                                               input logic [1:0] step);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(step);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    // Ticks always proceed; reads wait for room in the result register
    assign is_tick   = (item.opcode == kpef_pkg::OP_TICK);
    assign item_take = item_valid && (is_tick || res_free);
    assign tick_fire = item_take && is_tick;
    assign pop       = item_take && !is_tick && (count_reg != '0);

    // Find press edges and give each one a slot in key order
    assign edges = prev_levels_reg & ~item.key_levels;
    assign space = CW'(QUEUE_DEPTH) - count_reg;

    always_comb
    begin
        pushed = 2'd0;
        for (int k = 0; k < kpef_pkg::NUM_KEYS; k++)
        begin
            wr_en[k]   = tick_fire && edges[k] && (OW'(pushed) < OW'(space));
            wr_addr[k] = slot_add(wr_slot_reg, pushed);
            if (wr_en[k])
            begin
                pushed = pushed + 2'd1;
            end
        end
    end

    // Next state of the levels, slots and fill count
    always_comb
    begin
        prev_levels_next = prev_levels_reg;
        wr_slot_next     = wr_slot_reg;
        rd_slot_next     = rd_slot_reg;
        count_next       = count_reg;
        if (tick_fire)
        begin
            prev_levels_next = item.key_levels;
            wr_slot_next     = slot_add(wr_slot_reg, pushed);
            count_next       = count_reg + CW'(pushed);
        end
        else if (pop)
        begin
            rd_slot_next = slot_add(rd_slot_reg, 2'd1);
            count_next   = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= kpef_pkg::LEVELS_RELEASED;
            wr_slot_reg     <= '0;
            rd_slot_reg     <= '0;
            count_reg       <= '0;
        end
        else
        begin
            prev_levels_reg <= prev_levels_next;
            wr_slot_reg     <= wr_slot_next;
            rd_slot_reg     <= rd_slot_next;
            count_reg       <= count_next;
        end
    end

    // Write the accepted codes; slots within one tick never collide
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < kpef_pkg::NUM_KEYS; k++)
        begin
            if (wr_en[k])
            begin
                store[wr_addr[k]] <= key_codes[k];
            end
        end
    end

    // Read result: oldest code, or zero with the empty flag
    assign res_valid           = item_take && !is_tick;
    assign res.queue_was_empty = (count_reg == '0);
    assign res.key_code        = (count_reg == '0) ? '0 : store[rd_slot_reg];

endmodule

/* rtl/core/kpef_out_reg.sv */
module kpef_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  kpef_pkg::result_t res,
    output logic              res_free,
    output logic              out_valid,
    input  logic              out_ready,
    output kpef_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    kpef_pkg::result_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign res_free   = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* rtl/core/key_press_event_fifo.sv */
// Press-edge detector for three active-low keys feeding a ring FIFO of key codes.
// A slave beat with tuser 0 is a sample tick (tdata[2:0] = key levels, 0 = pressed);
// every key that goes from released to pressed pushes its configured code, key 0
// first, and pushes into a full queue are dropped. A beat with tuser 1 is a read:
// it yields one master beat with the oldest code, or code 0 and tuser 1 when the
// queue is empty. One beat is accepted every cycle as long as results are taken;
// a beat is held in the input register, and a read result is then registered in
// the output register. Only a stalled master side slows the input, and then only
// for reads. Key codes are written over the APB port at byte addresses 0, 4 and 8
// and should be changed only while the block is idle.
module key_press_event_fifo
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] key_levels, [7:3] zero
    input  logic        s_axis_tuser,   // [0] opcode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] key_code
    output logic        m_axis_tuser    // [0] queue_was_empty
);

    kpef_pkg::code_t     first_code_reg;
    kpef_pkg::code_t     second_code_reg;
    kpef_pkg::code_t     third_code_reg;
    kpef_pkg::code_set_t key_codes;

    logic                cfg_write;
    logic [1:0]          reg_index;

    kpef_pkg::item_t     in_item;
    kpef_pkg::item_t     item;
    logic                item_valid;
    logic                item_take;
    logic                res_valid;
    logic                res_free;
    kpef_pkg::result_t   res;
    kpef_pkg::result_t   out_res;

    // Register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[kpef_pkg::REG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg  <= kpef_pkg::FIRST_KEY_CODE_RST;
            second_code_reg <= kpef_pkg::SECOND_KEY_CODE_RST;
            third_code_reg  <= kpef_pkg::THIRD_KEY_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                kpef_pkg::REG_FIRST_KEY_CODE:  first_code_reg  <= pwdata[7:0];
                kpef_pkg::REG_SECOND_KEY_CODE: second_code_reg <= pwdata[7:0];
                kpef_pkg::REG_THIRD_KEY_CODE:  third_code_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            kpef_pkg::REG_FIRST_KEY_CODE:  prdata = {24'd0, first_code_reg};
            kpef_pkg::REG_SECOND_KEY_CODE: prdata = {24'd0, second_code_reg};
            kpef_pkg::REG_THIRD_KEY_CODE:  prdata = {24'd0, third_code_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    assign key_codes[0] = first_code_reg;
    assign key_codes[1] = second_code_reg;
    assign key_codes[2] = third_code_reg;

    // Unpack the slave beat
    assign in_item.opcode     = kpef_pkg::opcode_t'(s_axis_tuser);
    assign in_item.key_levels = s_axis_tdata[kpef_pkg::LEVEL_W-1:0];

    kpef_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    kpef_edge_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_edge_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_codes  (key_codes),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_free   (res_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    kpef_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.key_code;
    assign m_axis_tuser = out_res.queue_was_empty;

endmodule

/* rtl/core/kpef_checker.sv */
module kpef_port_props
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // A stalled master beat stays valid
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("master beat dropped while stalled");

    // A stalled master beat keeps its payload
    a_m_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("master payload changed while stalled");

    // An empty read carries code zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("empty read with nonzero code");

    // Input never stalls while the output side can take a beat
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("slave stalled with free output");

    // Nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("master beat valid right after reset");

endmodule

bind key_press_event_fifo kpef_port_props u_kpef_port_props (.*);

/* dv/kpef_checker.sv */
`timescale 1ns / 100ps

module kpef_checker
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] key_levels, [7:3] zero
    input  logic        s_axis_tuser,   // [0] opcode

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] key_code
    input  logic        m_axis_tuser,   // [0] queue_was_empty

    output int unsigned mismatch_count,
    output int unsigned codes_owed
);

    // Shadow copy of the block's registers and queue
    kpef_pkg::code_set_t          key_code_regs;
    logic [kpef_pkg::LEVEL_W-1:0] held_levels;
    kpef_pkg::code_t              ring [QUEUE_DEPTH];
    int unsigned                  wr_slot;
    int unsigned                  rd_slot;
    int unsigned                  fill;

    // Read results still to come out of the master side, oldest first
    kpef_pkg::result_t            owed_results [$];
    int unsigned                  errors = 0;

    // Push one code, drop it when the queue is full
    task automatic push_code(input kpef_pkg::code_t code);
        if (fill < QUEUE_DEPTH)
        begin
            ring[wr_slot] = code;
            wr_slot       = (wr_slot + 1) % QUEUE_DEPTH;
            fill++;
        end
    endtask

    // Sample tick: queue one code per press edge, key 0 first
    task automatic latch_levels(input logic [kpef_pkg::LEVEL_W-1:0] levels);
        for (int k = 0; k < kpef_pkg::NUM_KEYS; k++)
        begin
            if (held_levels[k] && !levels[k])
                push_code(key_code_regs[k]);
        end
        held_levels = levels;
    endtask

    // Read: pop the oldest code, or flag an empty queue
    task automatic pop_code();
        kpef_pkg::result_t res;
        if (fill == 0)
        begin
            res.key_code        = '0;
            res.queue_was_empty = 1'b1;
        end
        else
        begin
            res.key_code        = ring[rd_slot];
            res.queue_was_empty = 1'b0;
            rd_slot             = (rd_slot + 1) % QUEUE_DEPTH;
            fill--;
        end
        owed_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kpef_pkg::result_t exp_res;
        if (!rst_n)
        begin
            key_code_regs[0] = kpef_pkg::FIRST_KEY_CODE_RST;
            key_code_regs[1] = kpef_pkg::SECOND_KEY_CODE_RST;
            key_code_regs[2] = kpef_pkg::THIRD_KEY_CODE_RST;
            held_levels      = kpef_pkg::LEVELS_RELEASED;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                ring[i] = '0;
            wr_slot = 0;
            rd_slot = 0;
            fill    = 0;
            owed_results.delete();
        end
        else
        begin
            // Track register writes; unmapped addresses are ignored
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    kpef_pkg::REG_FIRST_KEY_CODE:
                        key_code_regs[0] = pwdata[kpef_pkg::CODE_W-1:0];
                    kpef_pkg::REG_SECOND_KEY_CODE:
                        key_code_regs[1] = pwdata[kpef_pkg::CODE_W-1:0];
                    kpef_pkg::REG_THIRD_KEY_CODE:
                        key_code_regs[2] = pwdata[kpef_pkg::CODE_W-1:0];
                    default: ;
                endcase
            end

            // Predict on every accepted input beat
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (kpef_pkg::opcode_t'(s_axis_tuser) == kpef_pkg::OP_READ)
                    pop_code();
                else
                    latch_levels(s_axis_tdata[kpef_pkg::LEVEL_W-1:0]);
            end

            // Compare every accepted result beat with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result beat code=%02h empty=%0b",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    exp_res = owed_results.pop_front();
                    if (m_axis_tdata !== exp_res.key_code ||
                        m_axis_tuser !== exp_res.queue_was_empty)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: result mismatch code exp %02h got %02h, ",
                                      "empty exp %0b got %0b"},
                                     $realtime, exp_res.key_code, m_axis_tdata,
                                     exp_res.queue_was_empty, m_axis_tuser);
                    end
                end
            end
        end
        codes_owed     <= owed_results.size();
        mismatch_count <= errors;
    end

endmodule

/* dv/tb_key_press_event_fifo.sv */
`timescale 1ns / 100ps

module tb_key_press_event_fifo;

    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PHASE_ITEMS   = 630;
    localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

    logic        clk;
    logic        rst_n         = 1'b0;

    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [2:0] key_levels, [7:3] zero
    logic        s_axis_tuser  = 1'b0;  // [0] opcode

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] key_code
    logic        m_axis_tuser;          // [0] queue_was_empty

    int unsigned mismatch_count;
    int unsigned codes_owed;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    key_press_event_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kpef_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .codes_owed     (codes_owed)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_key_press_event_fifo: errors");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Write one key code register; upper data bits carry noise
    task automatic write_code(input logic [1:0] idx, input kpef_pkg::code_t code);
        logic [31:0] noise;
        noise    = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise[31:kpef_pkg::CODE_W], code};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one beat after a random gap, hold until accepted
    task automatic send_beat(input kpef_pkg::opcode_t op,
                             input logic [kpef_pkg::LEVEL_W-1:0] levels);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(8 - kpef_pkg::LEVEL_W){1'b0}}, levels};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Hold off the input until every read result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (codes_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random bursts that lean toward filling or draining the queue
    task automatic run_random(input int unsigned count);
        int unsigned read_pct;
        int unsigned burst_left;
        int unsigned n;
        read_pct   = 50;
        burst_left = 0;
        for (n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0:       read_pct = 15;
                    1:       read_pct = 50;
                    default: read_pct = 85;
                endcase
            end
            if (n == count / 2)
                drain_results();
            if ($urandom_range(0, 99) < read_pct)
                send_beat(kpef_pkg::OP_READ, kpef_pkg::LEVEL_W'($urandom_range(0, 7)));
            else
                send_beat(kpef_pkg::OP_TICK, kpef_pkg::LEVEL_W'($urandom_range(0, 7)));
            burst_left--;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, all keys at once, single keys, overflow
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_beat(kpef_pkg::OP_READ, 3'b111);
        send_beat(kpef_pkg::OP_TICK, 3'b111);
        send_beat(kpef_pkg::OP_TICK, 3'b000);
        send_beat(kpef_pkg::OP_READ, 3'b000);
        send_beat(kpef_pkg::OP_READ, 3'b101);
        send_beat(kpef_pkg::OP_READ, 3'b010);
        send_beat(kpef_pkg::OP_TICK, 3'b111);
        send_beat(kpef_pkg::OP_TICK, 3'b110);
        send_beat(kpef_pkg::OP_TICK, 3'b101);
        send_beat(kpef_pkg::OP_TICK, 3'b011);
        send_beat(kpef_pkg::OP_TICK, 3'b111);
        send_beat(kpef_pkg::OP_TICK, 3'b000);
        send_beat(kpef_pkg::OP_TICK, 3'b111);
        send_beat(kpef_pkg::OP_TICK, 3'b000);
        send_beat(kpef_pkg::OP_READ, 3'b111);
        send_beat(kpef_pkg::OP_READ, 3'b111);
        send_beat(kpef_pkg::OP_READ, 3'b111);
        send_beat(kpef_pkg::OP_READ, 3'b111);
        send_beat(kpef_pkg::OP_READ, 3'b111);
        send_beat(kpef_pkg::OP_READ, 3'b000);
        drain_results();

        // Extreme codes, plus a write to an unmapped address
        write_code(kpef_pkg::REG_FIRST_KEY_CODE, 8'h00);
        write_code(kpef_pkg::REG_SECOND_KEY_CODE, 8'hff);
        write_code(kpef_pkg::REG_THIRD_KEY_CODE, 8'h00);
        write_code(REG_UNMAPPED, 8'hff);
        send_idle_pct = 24;
        recv_idle_pct = 66;
        run_random(PHASE_ITEMS);
        drain_results();

        write_code(kpef_pkg::REG_FIRST_KEY_CODE, kpef_pkg::code_t'($urandom()));
        write_code(kpef_pkg::REG_SECOND_KEY_CODE, kpef_pkg::code_t'($urandom()));
        write_code(kpef_pkg::REG_THIRD_KEY_CODE, kpef_pkg::code_t'($urandom()));
        send_idle_pct = 66;
        recv_idle_pct = 24;
        run_random(PHASE_ITEMS);
        drain_results();

        write_code(kpef_pkg::REG_FIRST_KEY_CODE, 8'hff);
        write_code(kpef_pkg::REG_SECOND_KEY_CODE, 8'h00);
        write_code(kpef_pkg::REG_THIRD_KEY_CODE, 8'hff);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_key_press_event_fifo: clean");
        else
            $display("tb_key_press_event_fifo: errors");
        $finish;
    end

endmodule
